/* hw/rtl/utd_pkg.sv */
// Shared types, constants and lead-byte decode for the UTF-8 decoder.
`timescale 1ns / 1ps
`default_nettype none
package utd_pkg;

   localparam int unsigned CP_W    = 31;
   localparam int unsigned COUNT_W = 3;

   localparam logic [COUNT_W-1:0] SINGLE_BYTE = 3'd1;
   localparam logic [1:0]         CONT_TAG    = 2'b10;

   // Result of classifying one byte as a lead byte
   typedef struct packed {
      logic [COUNT_W-1:0] len;   // 0 = not a lead byte
      logic [4:0]         pay;   // payload bits of the lead byte
   } lead_type;

   // Work handed from the front to the back: a flush of the open sequence
   // (lead byte plus taken continuation bytes), then an optional tail result
   typedef struct packed {
      logic [COUNT_W-1:0] flush_n;
      logic [7:0]         lead;
      logic [CP_W-1:0]    acc;
      logic               tail_valid;
      logic [CP_W-1:0]    tail_value;
      logic [COUNT_W-1:0] tail_count;
      logic               stream_end;
   } cmd_type;

   function automatic lead_type decode_lead(input logic [7:0] b);
      lead_type d;
      d = '0;
      if ((b & 8'hE0) == 8'hC0) begin
         d.len = 3'd2;
         d.pay = b[4:0] & 5'h1F;
      end else if ((b & 8'hF0) == 8'hE0) begin
         d.len = 3'd3;
         d.pay = {1'b0, b[3:0]};
      end else if ((b & 8'hF8) == 8'hF0) begin
         d.len = 3'd4;
         d.pay = {2'b0, b[2:0]};
      end else if ((b & 8'hFC) == 8'hF8) begin
         d.len = 3'd5;
         d.pay = {3'b0, b[1:0]};
      end else if ((b & 8'hFE) == 8'hFC) begin
         d.len = 3'd6;
         d.pay = {4'b0, b[0]};
      end
      return d;
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/utd_if.sv */
// Valid/ready channel interfaces for the byte input and the code point output.
`timescale 1ns / 1ps
`default_nettype none
interface utd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       stream_end;

   modport source (output valid, output data_byte, output stream_end, input ready);
   modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

interface utd_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [utd_pkg::CP_W-1:0]             code_point;
   logic [utd_pkg::COUNT_W-1:0]          byte_count;
   logic                                 run_last;
   logic                                 final_char;

   modport source (output valid, output code_point, output byte_count,
                   output run_last, output final_char, input ready);
   modport sink   (input valid, input code_point, input byte_count,
                   input run_last, input final_char, output ready);
endinterface
`default_nettype wire

/* hw/rtl/utd_front.sv */
// Front end: accepts bytes, tracks the open sequence and issues commands.
`timescale 1ns / 1ps
`default_nettype none
module utd_front (
   input  logic              clock,
   input  logic              reset,
   utd_req_if.sink           req_if,
   input  logic              q_full,
   output logic              push,
   output utd_pkg::cmd_type  cmd
);

   logic [7:0]                     lead_ff, lead_in;
   logic [utd_pkg::CP_W-1:0]       acc_ff, acc_in;
   logic [utd_pkg::COUNT_W-1:0]    exp_ff, exp_in;
   logic [utd_pkg::COUNT_W-1:0]    taken_ff, taken_in;

   logic                           accept;
   logic                           open_seq;
   logic                           is_cont;
   logic [utd_pkg::CP_W-1:0]       acc_new;
   logic [utd_pkg::COUNT_W-1:0]    taken_new;
   utd_pkg::lead_type              dec;

   assign req_if.ready = !q_full;
   assign accept       = req_if.valid && !q_full;
   assign open_seq     = exp_ff != '0;
   assign is_cont      = req_if.data_byte[7:6] == utd_pkg::CONT_TAG;
   assign acc_new      = {acc_ff[utd_pkg::CP_W-7:0], req_if.data_byte[5:0]};
   assign taken_new    = taken_ff + utd_pkg::SINGLE_BYTE;
   assign dec          = utd_pkg::decode_lead(req_if.data_byte);

   always_comb begin
      lead_in  = lead_ff;
      acc_in   = acc_ff;
      exp_in   = exp_ff;
      taken_in = taken_ff;
      cmd      = '0;
      if (open_seq && is_cont) begin
         if (taken_new >= exp_ff) begin
            // sequence complete
            cmd.tail_valid = 1'b1;
            cmd.tail_value = acc_new;
            cmd.tail_count = exp_ff;
            lead_in  = '0;
            acc_in   = '0;
            exp_in   = '0;
            taken_in = '0;
         end else if (req_if.stream_end) begin
            // cut short by the end of the stream: drop to single bytes
            cmd.flush_n = taken_new;
            cmd.lead    = lead_ff;
            cmd.acc     = acc_new;
            lead_in  = '0;
            acc_in   = '0;
            exp_in   = '0;
            taken_in = '0;
         end else begin
            acc_in   = acc_new;
            taken_in = taken_new;
         end
      end else begin
         if (open_seq) begin
            // bad continuation: flush what was taken, then decode afresh
            cmd.flush_n = taken_ff;
            cmd.lead    = lead_ff;
            cmd.acc     = acc_ff;
         end
         if (dec.len != '0 && !req_if.stream_end) begin
            lead_in  = req_if.data_byte;
            acc_in   = {{(utd_pkg::CP_W-5){1'b0}}, dec.pay};
            exp_in   = dec.len;
            taken_in = utd_pkg::SINGLE_BYTE;
         end else begin
            // plain byte, or a lead byte at the very end: stands for itself
            cmd.tail_valid = 1'b1;
            cmd.tail_value = {{(utd_pkg::CP_W-8){1'b0}}, req_if.data_byte};
            cmd.tail_count = utd_pkg::SINGLE_BYTE;
            lead_in  = '0;
            acc_in   = '0;
            exp_in   = '0;
            taken_in = '0;
         end
      end
      cmd.stream_end = req_if.stream_end;
   end

   assign push = accept && (cmd.flush_n != '0 || cmd.tail_valid);

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_ff  <= '0;
         acc_ff   <= '0;
         exp_ff   <= '0;
         taken_ff <= '0;
      end else if (accept) begin
         lead_ff  <= lead_in;
         acc_ff   <= acc_in;
         exp_ff   <= exp_in;
         taken_ff <= taken_in;
      end
   end

`ifndef ASSERT_OFF
   a_taken_bounded: assert property (@(posedge clock) disable iff (reset)
      taken_ff <= exp_ff)
      else $error("utd_front: more bytes taken than the sequence length");

   a_open_consistent: assert property (@(posedge clock) disable iff (reset)
      (exp_ff == '0) == (taken_ff == '0))
      else $error("utd_front: sequence length and taken count disagree");
`endif

endmodule
`default_nettype wire

/* hw/rtl/utd_cmd_queue.sv */
// Short command queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module utd_cmd_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  utd_pkg::cmd_type  push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output utd_pkg::cmd_type  head_cmd
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   utd_pkg::cmd_type        slot_ff [DEPTH];
   logic [PTR_W-1:0]        wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]        count_ff;

   assign full       = count_ff == FULL_CNT;
   assign head_valid = count_ff != '0;
   assign head_cmd   = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("utd_cmd_queue: push into a full queue");
`endif

endmodule
`default_nettype wire

/* hw/rtl/utd_back.sv */
// Back end: expands each command into results, one per cycle unless stalled.
`timescale 1ns / 1ps
`default_nettype none
module utd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  utd_pkg::cmd_type  head_cmd,
   output logic              pop,
   utd_rsp_if.source         rsp_if
);

   logic [utd_pkg::COUNT_W-1:0]   idx_ff, idx_in;
   logic                          out_valid_ff;
   logic [utd_pkg::CP_W-1:0]      cp_ff;
   logic [utd_pkg::COUNT_W-1:0]   cnt_ff;
   logic                          run_last_ff;
   logic                          final_ff;

   logic                          advance;
   logic                          take;
   logic                          in_flush;
   logic                          last_item;
   logic [utd_pkg::COUNT_W-1:0]   n_items;
   logic [utd_pkg::COUNT_W-1:0]   group_sel;
   logic [5:0]                    group_bits;
   logic [utd_pkg::CP_W-1:0]      item_cp;
   logic [utd_pkg::COUNT_W-1:0]   item_cnt;

   assign advance   = !out_valid_ff || rsp_if.ready;
   assign take      = advance && head_valid;
   assign n_items   = head_cmd.flush_n + {{(utd_pkg::COUNT_W-1){1'b0}}, head_cmd.tail_valid};
   assign in_flush  = idx_ff < head_cmd.flush_n;
   assign last_item = (idx_ff + utd_pkg::SINGLE_BYTE) == n_items;
   assign pop       = take && last_item;
   assign idx_in    = last_item ? '0 : idx_ff + utd_pkg::SINGLE_BYTE;

   // continuation byte k of the flush sits at six-bit group (taken - 1 - k)
   assign group_sel = head_cmd.flush_n - utd_pkg::SINGLE_BYTE - idx_ff;

   always_comb begin
      case (group_sel[1:0])
         2'd0:    group_bits = head_cmd.acc[5:0];
         2'd1:    group_bits = head_cmd.acc[11:6];
         2'd2:    group_bits = head_cmd.acc[17:12];
         2'd3:    group_bits = head_cmd.acc[23:18];
         default: group_bits = '0;
      endcase
   end

   always_comb begin
      if (in_flush && idx_ff == '0) begin
         item_cp  = {{(utd_pkg::CP_W-8){1'b0}}, head_cmd.lead};
         item_cnt = utd_pkg::SINGLE_BYTE;
      end else if (in_flush) begin
         item_cp  = {{(utd_pkg::CP_W-8){1'b0}}, utd_pkg::CONT_TAG, group_bits};
         item_cnt = utd_pkg::SINGLE_BYTE;
      end else begin
         item_cp  = head_cmd.tail_value;
         item_cnt = head_cmd.tail_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else if (take) begin
         idx_ff       <= idx_in;
         out_valid_ff <= 1'b1;
      end else if (advance) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cp_ff       <= item_cp;
         cnt_ff      <= item_cnt;
         run_last_ff <= last_item;
         final_ff    <= last_item && head_cmd.stream_end;
      end
   end

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.code_point = cp_ff;
   assign rsp_if.byte_count = cnt_ff;
   assign rsp_if.run_last   = run_last_ff;
   assign rsp_if.final_char = final_ff;

`ifndef ASSERT_OFF
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> idx_ff < n_items)
      else $error("utd_back: item index beyond the command's results");
`endif

endmodule
`default_nettype wire

/* hw/rtl/utf8_to_codepoint_decoder_top.sv */
// Top level of the UTF-8 to code point decoder.
//
//   channel  dir  payload                                        handshake
//   req_if   in   data_byte[7:0], stream_end                     valid/ready
//   rsp_if   out  code_point[30:0], byte_count[2:0], run_last,   valid/ready
//                 final_char
//
// A byte is accepted whenever the command queue has room, so a clean stream
// runs at one byte per cycle. Each command is played out by the back end at
// one result per cycle while rsp_if is ready, so a fallback yielding N results
// (N up to 6) holds the queue head and stalls the input once the queue fills.
// A byte's command is registered in a queue slot, then its result in the back end.
// Reset is synchronous and clears the open sequence, the queue and the output.
// The queue lets the front keep accepting while rsp_if is stalled, until it fills.
`timescale 1ns / 1ps
`default_nettype none
module utf8_to_codepoint_decoder_top #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic      clock,
   input  logic      reset,
   utd_req_if.sink   req_if,
   utd_rsp_if.source rsp_if
);

   // front to queue
   logic             push;
   utd_pkg::cmd_type push_cmd;
   logic             q_full;

   // queue to back
   logic             pop;
   logic             head_valid;
   utd_pkg::cmd_type head_cmd;

   // Classify each byte and advance the sequence state
   utd_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .q_full (q_full),
      .push   (push),
      .cmd    (push_cmd)
   );

   // Decouple the byte rate from bursts of fallback results
   utd_cmd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // Play each command out as one or more result transactions
   utd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_if     (rsp_if)
   );

endmodule
`default_nettype wire

/* tb/utd_decode_checker.sv */
// Channel monitor that predicts code points from accepted bytes and checks every result.
`timescale 1ns / 1ps
module utd_decode_checker (
   input  logic        clock,
   input  logic        reset,
   utd_req_if          byte_mon,
   utd_rsp_if          cp_mon,
   output int unsigned expected_left,
   output int unsigned mismatch_count,
   output int unsigned results_checked
);
   import utd_pkg::*;

   typedef struct packed {
      logic [CP_W-1:0]    code_point;
      logic [COUNT_W-1:0] byte_count;
      logic               run_last;
      logic               final_char;
   } cp_result_type;

   cp_result_type expected_cps[$];
   cp_result_type step_cps[$];

   // open sequence as the predictor sees it
   logic [7:0]         open_lead;
   logic [CP_W-1:0]    open_acc;
   logic [COUNT_W-1:0] open_len;
   logic [COUNT_W-1:0] open_taken;

   int unsigned fail_total;
   int unsigned seen_total;
   int unsigned pending_total;

   assign expected_left   = pending_total;
   assign mismatch_count  = fail_total;
   assign results_checked = seen_total;

   function automatic void log_failure(input string msg);
      fail_total++;
      if (fail_total <= 10) $display("%0t ns: %s", $time, msg);
   endfunction

   function automatic void push_char(input logic [CP_W-1:0] cp,
                                     input logic [COUNT_W-1:0] cnt);
      cp_result_type r;
      if (step_cps.size() < 6) begin
         r.code_point = cp;
         r.byte_count = cnt;
         r.run_last   = 1'b0;
         r.final_char = 1'b0;
         step_cps.push_back(r);
      end
   endfunction

   function automatic void close_sequence();
      open_lead  = '0;
      open_acc   = '0;
      open_len   = '0;
      open_taken = '0;
   endfunction

   // Give back the lead and each taken continuation byte as single bytes.
   function automatic void spill_sequence();
      int k;
      int shift;
      logic [CP_W-1:0] bits;
      push_char(CP_W'(open_lead), SINGLE_BYTE);
      for (k = 1; k < int'(open_taken) && k < 6; k++) begin
         shift = 6 * (int'(open_taken) - 1 - k);
         bits  = open_acc >> shift;
         push_char(CP_W'({CONT_TAG, bits[5:0]}), SINGLE_BYTE);
      end
      close_sequence();
   endfunction

   function automatic void decode_byte_into_expected(input logic [7:0] b,
                                                     input logic last_in_stream);
      logic               start_new;
      logic [COUNT_W-1:0] len;
      logic [CP_W-1:0]    payload;
      cp_result_type      r;
      step_cps.delete();
      start_new = 1'b1;
      if (open_len != '0) begin
         if (b[7:6] == CONT_TAG) begin
            start_new  = 1'b0;
            open_acc   = {open_acc[CP_W-7:0], b[5:0]};
            open_taken = open_taken + 1'b1;
            if (open_taken >= open_len) begin
               push_char(open_acc, open_len);
               close_sequence();
            end else if (last_in_stream) begin
               spill_sequence();
            end
         end else begin
            spill_sequence();
         end
      end
      if (start_new) begin
         len     = '0;
         payload = '0;
         casez (b)
            8'b110?????: begin len = 3'd2; payload = CP_W'(b[4:0]); end
            8'b1110????: begin len = 3'd3; payload = CP_W'(b[3:0]); end
            8'b11110???: begin len = 3'd4; payload = CP_W'(b[2:0]); end
            8'b111110??: begin len = 3'd5; payload = CP_W'(b[1:0]); end
            8'b1111110?: begin len = 3'd6; payload = CP_W'(b[0]); end
            default: ;
         endcase
         if (len != '0) begin
            open_lead  = b;
            open_acc   = payload;
            open_len   = len;
            open_taken = 3'd1;
            if (last_in_stream) spill_sequence();
         end else begin
            push_char(CP_W'(b), SINGLE_BYTE);
         end
      end
      if (step_cps.size() > 0) begin
         r = step_cps.pop_back();
         r.run_last   = 1'b1;
         r.final_char = last_in_stream;
         step_cps.push_back(r);
      end
      foreach (step_cps[i]) expected_cps.push_back(step_cps[i]);
   endfunction

   always @(posedge clock) begin
      cp_result_type want;
      cp_result_type got;
      if (reset) begin
         close_sequence();
         expected_cps.delete();
      end else begin
         if (byte_mon.valid && byte_mon.ready)
            decode_byte_into_expected(byte_mon.data_byte, byte_mon.stream_end);
         if (cp_mon.valid && cp_mon.ready) begin
            seen_total++;
            got.code_point = cp_mon.code_point;
            got.byte_count = cp_mon.byte_count;
            got.run_last   = cp_mon.run_last;
            got.final_char = cp_mon.final_char;
            if (expected_cps.size() == 0) begin
               log_failure($sformatf("unexpected result cp=%h count=%0d last=%b final=%b",
                  got.code_point, got.byte_count, got.run_last, got.final_char));
            end else begin
               want = expected_cps.pop_front();
               if (got.code_point !== want.code_point ||
                   got.byte_count !== want.byte_count ||
                   got.run_last !== want.run_last ||
                   got.final_char !== want.final_char)
                  log_failure({
                     $sformatf("result %0d: expected cp=%h count=%0d last=%b final=%b",
                        seen_total, want.code_point, want.byte_count, want.run_last,
                        want.final_char),
                     $sformatf(", got cp=%h count=%0d last=%b final=%b",
                        got.code_point, got.byte_count, got.run_last, got.final_char)});
            end
         end
      end
      pending_total = expected_cps.size();
   end

   initial begin
      fail_total    = 0;
      seen_total    = 0;
      pending_total = 0;
   end

endmodule

/* tb/utf8_to_codepoint_decoder_top_tb.sv */
// Testbench top for the UTF-8 decoder: clock, reset, byte stimulus, result back-pressure and verdict.
`timescale 1ns / 1ps
module utf8_to_codepoint_decoder_top_tb;
   import utd_pkg::*;

   localparam int CLK_PERIOD   = 8;
   localparam int QUIET_LIMIT  = 4000;  // cycles with no transaction on either channel
   localparam int RANDOM_ITEMS = 350;
   localparam int CALM_TAIL    = 60;    // last bytes go out with no idling on either side
   localparam int SETTLE       = 20;    // cycles to catch stray results after the drain
   localparam int DIRECTED_LEN = 22;

   // {stream_end, data_byte}
   localparam logic [8:0] DIRECTED_SEQ [DIRECTED_LEN] = '{
      9'h000, 9'h07F,                          // ASCII extremes
      9'h0BF,                                  // stray continuation byte passes through
      9'h0FE, 9'h1FF,                          // never-lead bytes, FF closes a stream
      9'h0C3, 9'h0A9,                          // 2-byte form
      9'h0E2, 9'h082, 9'h0AC,                  // 3-byte form
      9'h0FD, 9'h0BF, 9'h0BF, 9'h0BF, 9'h0BF, 9'h0BF,  // 6-byte form, largest value
      9'h0E2, 9'h082, 9'h041,                  // bad continuation after two bytes
      9'h0F0, 9'h19F,                          // sequence cut short by stream end
      9'h1C0                                   // lead byte as final byte of a stream
   };

   logic clock;
   logic reset;

   utd_req_if byte_bus ();
   utd_rsp_if cp_bus ();

   int unsigned expected_left;
   int unsigned mismatch_count;
   int unsigned results_checked;

   int unsigned bytes_sent;
   int unsigned stream_ends;
   int unsigned quiet_cycles;
   bit          sender_idles;
   bit          receiver_stalls;
   int          stall_left;

   utf8_to_codepoint_decoder_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (byte_bus),
      .rsp_if (cp_bus)
   );

   utd_decode_checker u_cp_checker (
      .clock           (clock),
      .reset           (reset),
      .byte_mon        (byte_bus),
      .cp_mon          (cp_bus),
      .expected_left   (expected_left),
      .mismatch_count  (mismatch_count),
      .results_checked (results_checked)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // Result side: hold ready low in random bursts while stalls are enabled.
   initial begin
      cp_bus.ready = 1'b0;
      stall_left   = 0;
      forever begin
         @(negedge clock);
         if (receiver_stalls && stall_left == 0 && $urandom_range(0, 4) == 0)
            stall_left = $urandom_range(1, 7);
         cp_bus.ready <= (stall_left == 0);
         if (stall_left > 0) stall_left--;
      end
   end

   // Watchdog: give up once neither channel has moved a transaction for too long.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((byte_bus.valid && byte_bus.ready) || (cp_bus.valid && cp_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles, %0d results still due",
               QUIET_LIMIT, expected_left);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // Offer one byte from a falling edge; keep valid high straight into the next byte
   // unless an idle burst is drawn. Return at the falling edge after acceptance.
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      if (sender_idles && $urandom_range(0, 5) == 0) begin
         byte_bus.valid <= 1'b0;
         gap = $urandom_range(1, 7);
         repeat (gap) @(negedge clock);
      end
      byte_bus.valid      <= 1'b1;
      byte_bus.data_byte  <= b;
      byte_bus.stream_end <= last;
      @(posedge clock);
      while (!byte_bus.ready) @(posedge clock);
      @(negedge clock);
      bytes_sent++;
      if (last) stream_ends++;
   endtask

   // Drop valid and hold the sender back until every predicted result has come out.
   task automatic drain_results();
      byte_bus.valid <= 1'b0;
      @(negedge clock);
      while (expected_left != 0) @(negedge clock);
   endtask

   // One character: mostly well-formed 1- to 6-byte forms with random payload, some
   // truncated so that the next byte breaks them, some pure noise, and now and then
   // a stream end either on the last byte or part-way through.
   task automatic send_random_char();
      int         pick;
      int         len;
      int         keep;
      int         end_at;
      int         k;
      int         r;
      logic [7:0] seq[$];
      logic [7:0] lead;
      pick = $urandom_range(0, 99);
      r    = $urandom_range(0, 99);
      if (r < 30)      len = 1;
      else if (r < 50) len = 2;
      else if (r < 70) len = 3;
      else if (r < 82) len = 4;
      else if (r < 91) len = 5;
      else             len = 6;
      case (len)
         1:       lead = 8'($urandom_range(0, 127));
         2:       lead = {3'b110, 5'($urandom)};
         3:       lead = {4'b1110, 4'($urandom)};
         4:       lead = {5'b11110, 3'($urandom)};
         5:       lead = {6'b111110, 2'($urandom)};
         default: lead = {7'b1111110, 1'($urandom)};
      endcase
      seq.push_back(lead);
      for (k = 1; k < len; k++) seq.push_back({CONT_TAG, 6'($urandom)});
      if (pick >= 80 && pick < 92 && len > 1) begin
         keep = $urandom_range(1, len - 1);
         while (seq.size() > keep) void'(seq.pop_back());
      end else if (pick >= 92) begin
         seq.delete();
         seq.push_back(8'($urandom));
      end
      end_at = -1;
      if ($urandom_range(0, 11) == 0)
         end_at = seq.size() - 1;
      else if ($urandom_range(0, 24) == 0)
         end_at = $urandom_range(0, seq.size() - 1);
      if (end_at >= 0)
         while (seq.size() > end_at + 1) void'(seq.pop_back());
      for (k = 0; k < seq.size(); k++) send_byte(seq[k], k == end_at);
   endtask

   initial begin
      int i;
      reset               = 1'b1;
      byte_bus.valid      = 1'b0;
      byte_bus.data_byte  = 8'h00;
      byte_bus.stream_end = 1'b0;
      sender_idles        = 1'b0;
      receiver_stalls     = 1'b0;
      bytes_sent          = 0;
      stream_ends         = 0;

      // Hold reset, then release it on a falling edge.
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      sender_idles    = 1'b1;
      receiver_stalls = 1'b1;

      // Directed bytes: extremes, the 1-, 2-, 3- and 6-byte forms and each fallback case.
      for (i = 0; i < DIRECTED_LEN; i++)
         send_byte(DIRECTED_SEQ[i][7:0], DIRECTED_SEQ[i][8]);
      drain_results();

      // Random characters; advance into a calm tail with both sides running flat out.
      while (bytes_sent < DIRECTED_LEN + RANDOM_ITEMS) begin
         if (sender_idles && bytes_sent >= DIRECTED_LEN + RANDOM_ITEMS - CALM_TAIL) begin
            sender_idles    = 1'b0;
            receiver_stalls = 1'b0;
         end
         if ($urandom_range(0, 59) == 0) drain_results();
         send_random_char();
      end
      byte_bus.valid <= 1'b0;

      // Wait for the outstanding results, then a little longer for any stray ones.
      while (expected_left != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);

      $display("Sent %0d bytes across %0d stream ends; checked %0d code points",
         bytes_sent, stream_ends, results_checked);
      $display("Covered 1- to 6-byte forms, bad continuations, cut-short sequences; %0d mismatches",
         mismatch_count);
      if (mismatch_count == 0 && expected_left == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
